@@ rtl/core/p2b_pkg.sv @@
// Package of shared types and constants for the pixel to BGRA8 converter.
package p2b_pkg;

   // Source pixel layouts that the format register selects.
   typedef enum logic [2:0] {
      FMT_BGRA8   = 3'd0,
      FMT_RGBA8   = 3'd1,
      FMT_RGB10A2 = 3'd2,
      FMT_HALF    = 3'd3
   } pixel_format_type;

   localparam int unsigned PixelWidth  = 64;
   localparam int unsigned FormatWidth = 3;
   localparam int unsigned ChanCount   = 3;   // red, green, blue
   localparam int unsigned ProdWidth   = 19;  // 255 * (1024 + mantissa)
   localparam int unsigned ShiftWidth  = 5;   // shift of 11 to 24
   localparam int unsigned RoundWidth  = 25;  // product plus rounding bit
   localparam logic [7:0]  AlphaOpaque = 8'd255;

   // How one half-float channel resolves after classification.
   typedef enum logic [1:0] {
      HALF_ZERO   = 2'd0,
      HALF_FULL   = 2'd1,
      HALF_SCALED = 2'd2
   } half_class_type;

   // One half-float channel after the first stage.
   typedef struct packed {
      half_class_type         kind;
      logic [ProdWidth-1:0]   prod;
      logic [ShiftWidth-1:0]  shift;
   } half_chan_type;

   // Payload leaving the decode stage. Channel index 0 red, 1 green, 2 blue.
   typedef struct packed {
      logic [FormatWidth-1:0] fmt;
      logic                   row_end;
      logic [7:0]             direct_red;
      logic [7:0]             direct_green;
      logic [7:0]             direct_blue;
      half_chan_type [ChanCount-1:0] half;
   } decode_payload_type;

   // Payload leaving the rounding stage.
   typedef struct packed {
      logic [FormatWidth-1:0] fmt;
      logic                   row_end;
      logic [7:0]             direct_red;
      logic [7:0]             direct_green;
      logic [7:0]             direct_blue;
      logic [ChanCount-1:0][7:0] half_byte;
   } round_payload_type;

   // Handshake signals between neighbouring stages.
   typedef struct packed {
      logic valid;
   } stage_fwd_type;

   typedef struct packed {
      logic ready;
   } stage_bwd_type;

endpackage

@@ rtl/core/p2b_stream_if.sv @@
// Stream interfaces for the request and response channels of the converter.
interface p2b_req_if
   import p2b_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [PixelWidth-1:0] source_pixel;
   logic                  end_of_row;

   modport source (output valid, output source_pixel, output end_of_row, input ready);
   modport sink   (input valid, input source_pixel, input end_of_row, output ready);
endinterface

interface p2b_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic [7:0] alpha;
   logic       format_unsupported;
   logic       row_end_out;

   modport source (output valid, output blue, output green, output red, output alpha,
                   output format_unsupported, output row_end_out, input ready);
   modport sink   (input valid, input blue, input green, input red, input alpha,
                   input format_unsupported, input row_end_out, output ready);
endinterface

@@ rtl/core/p2b_decode_stage.sv @@
// First pipeline stage: byte extraction and half-float classification with the scale product.
module p2b_decode_stage
   import p2b_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  stage_fwd_type          up_fwd,
   output stage_bwd_type          up_bwd,
   input  logic [PixelWidth-1:0]  pixel,
   input  logic                   row_end,
   input  logic [FormatWidth-1:0] fmt,
   output stage_fwd_type          down_fwd,
   input  stage_bwd_type          down_bwd,
   output decode_payload_type     payload
);

   logic               valid_ff, valid_in;
   logic               advance;
   decode_payload_type data_ff, data_in;

   // The stage takes a transaction whenever it is empty or its content moves on.
   assign advance      = !valid_ff || down_bwd.ready;
   assign up_bwd.ready = advance;
   assign valid_in     = advance ? up_fwd.valid : valid_ff;

   // Classify one half-float channel and form 255 times its significand.
   function automatic half_chan_type classify(input logic [15:0] h);
      half_chan_type c;
      logic [4:0]    expo;
      logic [9:0]    mant;
      logic [10:0]   sig;
      expo    = h[14:10];
      mant    = h[9:0];
      sig     = {1'b1, mant};
      c.prod  = ProdWidth'({sig, 8'd0} - {8'd0, sig});
      c.shift = ShiftWidth'(5'd25 - expo);
      if (h[15]) begin
         c.kind = HALF_ZERO;
      end else if (expo == 5'h1F) begin
         c.kind = (mant == 10'd0) ? HALF_FULL : HALF_ZERO;
      end else if (expo == 5'd0) begin
         c.kind = HALF_ZERO;
      end else if (expo >= 5'd15) begin
         c.kind = HALF_FULL;
      end else begin
         c.kind = HALF_SCALED;
      end
      return c;
   endfunction

   // Decode of the byte-based layouts and the three half channels.
   always_comb begin
      data_in         = data_ff;
      data_in.fmt     = fmt;
      data_in.row_end = row_end;
      unique case (fmt)
         FMT_RGBA8: begin
            data_in.direct_red   = pixel[7:0];
            data_in.direct_green = pixel[15:8];
            data_in.direct_blue  = pixel[23:16];
         end
         FMT_RGB10A2: begin
            data_in.direct_red   = pixel[9:2];
            data_in.direct_green = pixel[19:12];
            data_in.direct_blue  = pixel[29:22];
         end
         default: begin
            data_in.direct_blue  = pixel[7:0];
            data_in.direct_green = pixel[15:8];
            data_in.direct_red   = pixel[23:16];
         end
      endcase
      data_in.half[0] = classify(pixel[15:0]);
      data_in.half[1] = classify(pixel[31:16]);
      data_in.half[2] = classify(pixel[47:32]);
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign down_fwd.valid = valid_ff;
   assign payload        = data_ff;

endmodule

@@ rtl/core/p2b_round_stage.sv @@
// Second pipeline stage: rounding and scaling of the half-float products to bytes.
module p2b_round_stage
   import p2b_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stage_fwd_type      up_fwd,
   output stage_bwd_type      up_bwd,
   input  decode_payload_type up_data,
   output stage_fwd_type      down_fwd,
   input  stage_bwd_type      down_bwd,
   output round_payload_type  payload
);

   logic              valid_ff, valid_in;
   logic              advance;
   round_payload_type data_ff, data_in;

   assign advance      = !valid_ff || down_bwd.ready;
   assign up_bwd.ready = advance;
   assign valid_in     = advance ? up_fwd.valid : valid_ff;

   // Add half of the last kept bit, then shift; the result never exceeds 255.
   always_comb begin
      logic [RoundWidth-1:0] sum;
      logic [RoundWidth-1:0] scaled;
      data_in              = data_ff;
      data_in.fmt          = up_data.fmt;
      data_in.row_end      = up_data.row_end;
      data_in.direct_red   = up_data.direct_red;
      data_in.direct_green = up_data.direct_green;
      data_in.direct_blue  = up_data.direct_blue;
      for (int i = 0; i < ChanCount; i++) begin
         sum    = RoundWidth'(up_data.half[i].prod)
                + (RoundWidth'(1) << (up_data.half[i].shift - ShiftWidth'(1)));
         scaled = sum >> up_data.half[i].shift;
         unique case (up_data.half[i].kind)
            HALF_FULL:   data_in.half_byte[i] = 8'd255;
            HALF_SCALED: data_in.half_byte[i] = scaled[7:0];
            default:     data_in.half_byte[i] = 8'd0;
         endcase
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign down_fwd.valid = valid_ff;
   assign payload        = data_ff;

endmodule

@@ rtl/core/p2b_output_stage.sv @@
// Third pipeline stage: format selection and the response output register.
module p2b_output_stage
   import p2b_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  stage_fwd_type     up_fwd,
   output stage_bwd_type     up_bwd,
   input  round_payload_type up_data,
   p2b_rsp_if.source         rsp
);

   logic       valid_ff, valid_in;
   logic       advance;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] red_ff, red_in;
   logic       bad_ff, bad_in;
   logic       row_end_ff;

   assign advance      = !valid_ff || rsp.ready;
   assign up_bwd.ready = advance;
   assign valid_in     = advance ? up_fwd.valid : valid_ff;

   // Pick the channel source by format; unknown formats give black and the flag.
   always_comb begin
      blue_in  = 8'd0;
      green_in = 8'd0;
      red_in   = 8'd0;
      bad_in   = 1'b0;
      unique case (up_data.fmt)
         FMT_BGRA8, FMT_RGBA8, FMT_RGB10A2: begin
            blue_in  = up_data.direct_blue;
            green_in = up_data.direct_green;
            red_in   = up_data.direct_red;
         end
         FMT_HALF: begin
            red_in   = up_data.half_byte[0];
            green_in = up_data.half_byte[1];
            blue_in  = up_data.half_byte[2];
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
   end

   // Output register; it holds its transaction while the sink stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         blue_ff    <= blue_in;
         green_ff   <= green_in;
         red_ff     <= red_in;
         bad_ff     <= bad_in;
         row_end_ff <= up_data.row_end;
      end
   end

   assign rsp.valid              = valid_ff;
   assign rsp.blue               = blue_ff;
   assign rsp.green              = green_ff;
   assign rsp.red                = red_ff;
   assign rsp.alpha              = AlphaOpaque;
   assign rsp.format_unsupported = bad_ff;
   assign rsp.row_end_out        = row_end_ff;

endmodule

@@ rtl/core/pixel_to_bgra8_converter_core.sv @@
// Top level of the pixel to BGRA8 converter: format register and three-stage pipeline.
//
//   Channel  Direction  Handshake          Payload
//   req      in         valid/ready        source_pixel[63:0], end_of_row
//   rsp      out        valid/ready        blue, green, red, alpha, format_unsupported,
//                                          row_end_out
//   csr      in         write enable only  csr_write_data[2:0] (pixel format)
//
// One transaction enters per clock while the response side does not stall; its result is
// presented once it has passed the three register stages: decode with the 11 by 8 bit scale
// product, half-float rounding shift, and format selection into the output register.
// Synchronous reset empties the pipeline and sets the format to BGRA8.
// A stall at the response side holds every stage; each stage still fills while empty.
module pixel_to_bgra8_converter_core
   import p2b_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   p2b_req_if.sink                req,
   p2b_rsp_if.source              rsp,
   input  logic                   csr_write_enable,
   input  logic [FormatWidth-1:0] csr_write_data
);

   logic [FormatWidth-1:0] format_ff;
   stage_fwd_type          req_fwd, dec_fwd, rnd_fwd;
   stage_bwd_type          req_bwd, dec_bwd, rnd_bwd;
   decode_payload_type     dec_data;
   round_payload_type      rnd_data;

   // Format register.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_BGRA8;
      end else if (csr_write_enable) begin
         format_ff <= csr_write_data;
      end
   end

   assign req_fwd.valid = req.valid;
   assign req.ready     = req_bwd.ready;

   // Pipeline stages.
   p2b_decode_stage u_decode (
      .clock    (clock),
      .reset    (reset),
      .up_fwd   (req_fwd),
      .up_bwd   (req_bwd),
      .pixel    (req.source_pixel),
      .row_end  (req.end_of_row),
      .fmt      (format_ff),
      .down_fwd (dec_fwd),
      .down_bwd (dec_bwd),
      .payload  (dec_data)
   );

   p2b_round_stage u_round (
      .clock    (clock),
      .reset    (reset),
      .up_fwd   (dec_fwd),
      .up_bwd   (dec_bwd),
      .up_data  (dec_data),
      .down_fwd (rnd_fwd),
      .down_bwd (rnd_bwd),
      .payload  (rnd_data)
   );

   p2b_output_stage u_output (
      .clock   (clock),
      .reset   (reset),
      .up_fwd  (rnd_fwd),
      .up_bwd  (rnd_bwd),
      .up_data (rnd_data),
      .rsp     (rsp)
   );

endmodule

@@ rtl/core/p2b_checker.sv @@
// Port-level checker for the converter and its bind to the top level.
module p2b_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha,
   input logic       rsp_format_unsupported,
   input logic       rsp_row_end_out
);

   // The pipeline is empty on the cycle after a reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid directly after reset");

   // Alpha is always opaque on a presented transaction.
   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha == 8'd255)
      else $error("alpha is not 255");

   // An unsupported format gives black channels.
   a_unsupported_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_format_unsupported |->
         rsp_blue == 8'd0 && rsp_green == 8'd0 && rsp_red == 8'd0)
      else $error("unsupported format with non-zero channels");

   // A stalled response stays and holds its payload.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blue) && $stable(rsp_green)
         && $stable(rsp_red) && $stable(rsp_format_unsupported)
         && $stable(rsp_row_end_out))
      else $error("stalled response changed");

endmodule

bind pixel_to_bgra8_converter_core p2b_checker u_p2b_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp.valid),
   .rsp_ready              (rsp.ready),
   .rsp_blue               (rsp.blue),
   .rsp_green              (rsp.green),
   .rsp_red                (rsp.red),
   .rsp_alpha              (rsp.alpha),
   .rsp_format_unsupported (rsp.format_unsupported),
   .rsp_row_end_out        (rsp.row_end_out)
);
